@@ design/iwpf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the IMU wild point filter.
// Used by iwpf_scale, iwpf_lane and imu_wild_point_filter; depends on nothing.
package iwpf_pkg;

	localparam int SAMPLE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF  = 8;

	localparam int FIELD_BITS     = 32;
	localparam int CFG_BITS       = 24;
	localparam int DROP_BITS      = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int AXES           = 6;
	localparam int ACC_AXES       = 3;

	// product LSB 2^-40 down to 2^-16
	localparam int ROUND_SHIFT = 24;

	localparam logic [CFG_BITS-1:0]  GRAVITY_SCALE_RST    = 24'd10283018;
	localparam logic [CFG_BITS-1:0]  ACC_TOLERANCE_RST    = 24'd6554;
	localparam logic [CFG_BITS-1:0]  GYRO_NOISE_FLOOR_RST = 24'd3355;
	localparam logic [DROP_BITS-1:0] MAX_ACC_DROPS_RST    = 8'd5;
	localparam logic [DROP_BITS-1:0] MAX_GYRO_DROPS_RST   = 8'd5;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRAVITY_SCALE    = 3'd0,
		REG_ACC_TOLERANCE    = 3'd1,
		REG_GYRO_NOISE_FLOOR = 3'd2,
		REG_MAX_ACC_DROPS    = 3'd3,
		REG_MAX_GYRO_DROPS   = 3'd4
	} cfg_reg_t;

	// Control from the merge stage to every lane.
	typedef struct packed {
		logic take;   // a sample leaves stage 2 and updates lane state
		logic first;  // no previous sample yet: pass without compare
	} lane_ctl_t;

endpackage

@@ design/iwpf_scale.sv @@
`timescale 1ns / 1ps
// Front end of one axis: gravity multiply (acceleration axes), rounding and
// saturation to the sample width. Two register stages. Uses iwpf_pkg.
module iwpf_scale #(
	parameter int SAMPLE_BITS = iwpf_pkg::SAMPLE_BITS_DEF,
	parameter bit ACC         = 1'b1
) (
	input  logic                                  clk,
	input  logic                                  en_s1,
	input  logic                                  en_s2,
	input  logic signed [iwpf_pkg::FIELD_BITS-1:0] raw,
	input  logic        [iwpf_pkg::CFG_BITS-1:0]   scale,
	output logic signed [SAMPLE_BITS-1:0]          cur_s2
);

	localparam int PROD_BITS = iwpf_pkg::FIELD_BITS + iwpf_pkg::CFG_BITS + 1;
	localparam int WIDE_BITS = iwpf_pkg::FIELD_BITS + 1;
	localparam int MW        = (SAMPLE_BITS > WIDE_BITS) ? SAMPLE_BITS : WIDE_BITS;
	localparam logic signed [MW-1:0] SAT_HI = MW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - MW'(1);

	logic signed [WIDE_BITS-1:0] wide;
	logic signed [MW-1:0]        ext;
	logic signed [SAMPLE_BITS-1:0] sat;

	generate
		if (ACC) begin : g_acc
			logic signed [PROD_BITS-1:0] prod_s1;
			logic signed [PROD_BITS-1:0] sum;

			always_ff @(posedge clk) begin
				if (en_s1) begin
					prod_s1 <= PROD_BITS'(raw) * PROD_BITS'($signed({1'b0, scale}));
				end
			end

			// round half up, then floor shift
			assign sum  = prod_s1 + PROD_BITS'(1 << (iwpf_pkg::ROUND_SHIFT - 1));
			assign wide = $signed(sum[iwpf_pkg::ROUND_SHIFT + WIDE_BITS - 1 :
				iwpf_pkg::ROUND_SHIFT]);
		end else begin : g_rate
			logic signed [iwpf_pkg::FIELD_BITS-1:0] raw_s1;

			always_ff @(posedge clk) begin
				if (en_s1) begin
					raw_s1 <= raw;
				end
			end

			assign wide = WIDE_BITS'(raw_s1);
		end
	endgenerate

	assign ext = MW'(wide);

	always_comb begin
		if (ext > SAT_HI) begin
			sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (ext < SAT_LO) begin
			sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			sat = ext[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cur_s2 <= sat;
		end
	end

endmodule

@@ design/iwpf_lane.sv @@
`timescale 1ns / 1ps
// One axis of the spike check: step compare against the previous sample,
// drop counter and held output. Uses iwpf_pkg.
module iwpf_lane #(
	parameter int SAMPLE_BITS = iwpf_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = iwpf_pkg::COUNT_BITS_DEF,
	parameter bit GYRO        = 1'b0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  iwpf_pkg::lane_ctl_t                    ctl,
	input  logic signed [SAMPLE_BITS-1:0]           cur,
	input  logic        [iwpf_pkg::CFG_BITS-1:0]    limit_cfg,
	input  logic        [iwpf_pkg::DROP_BITS-1:0]   max_drops,
	output logic signed [iwpf_pkg::FIELD_BITS-1:0]  held,
	output logic                                   rejected
);

	localparam int DW = SAMPLE_BITS + 1;
	localparam int LW = (DW > iwpf_pkg::CFG_BITS) ? DW : iwpf_pkg::CFG_BITS;
	localparam int CW = (COUNT_BITS > iwpf_pkg::DROP_BITS) ? COUNT_BITS : iwpf_pkg::DROP_BITS;

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] held_q;
	logic        [COUNT_BITS-1:0]  cnt_q;

	logic signed [DW-1:0]          diff;
	logic        [DW-1:0]          adiff;
	logic        [SAMPLE_BITS-1:0] aprev;
	logic        [DW-1:0]          twice;
	logic        [LW-1:0]          limit;
	logic                          pass;

	assign diff  = DW'(cur) - DW'(prev_q);
	assign adiff = diff[DW-1] ? DW'(-diff) : DW'(diff);
	assign aprev = prev_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-prev_q) : SAMPLE_BITS'(prev_q);
	assign twice = {aprev, 1'b0};

	always_comb begin
		if (GYRO) begin
			limit = (LW'(twice) > LW'(limit_cfg)) ? LW'(twice) : LW'(limit_cfg);
		end else begin
			limit = LW'(limit_cfg);
		end
	end

	// forced through once the counter has gone past the maximum
	assign pass     = (LW'(adiff) < limit) || (CW'(cnt_q) > CW'(max_drops));
	assign rejected = !ctl.first && !pass;
	assign held     = iwpf_pkg::FIELD_BITS'(held_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			held_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.take) begin
			prev_q <= cur;
			if (ctl.first || pass) begin
				held_q <= cur;
			end
			if (!ctl.first) begin
				if (pass) begin
					cnt_q <= '0;
				end else if (cnt_q != '1) begin
					cnt_q <= cnt_q + COUNT_BITS'(1);
				end
			end
		end
	end

endmodule

@@ design/imu_wild_point_filter.sv @@
`timescale 1ns / 1ps
// Wild point filter for six-axis IMU samples. Takes one sample per clock when
// out_ready does not stall the pipeline. The gravity multiply, the
// rounding and saturation, and the per-axis spike decision each own a
// register stage, and the decision loads the output register. Six lanes run
// the decision in parallel; the merge stage collects their reject bits into
// rejected_mask. A rejected axis repeats its last output. The very first
// sample after reset passes on every axis with a zero mask.
// Depends on iwpf_pkg, iwpf_scale, iwpf_lane.
module imu_wild_point_filter #(
	parameter int SAMPLE_BITS = iwpf_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = iwpf_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic                                      cfg_we,
	input  logic [iwpf_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [iwpf_pkg::CFG_BITS-1:0]             cfg_data,

	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [iwpf_pkg::FIELD_BITS-1:0]    acc_x_in,
	input  logic signed [iwpf_pkg::FIELD_BITS-1:0]    acc_y_in,
	input  logic signed [iwpf_pkg::FIELD_BITS-1:0]    acc_z_in,
	input  logic signed [iwpf_pkg::FIELD_BITS-1:0]    rate_x_in,
	input  logic signed [iwpf_pkg::FIELD_BITS-1:0]    rate_y_in,
	input  logic signed [iwpf_pkg::FIELD_BITS-1:0]    rate_z_in,

	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [iwpf_pkg::FIELD_BITS-1:0]    acc_x_out,
	output logic signed [iwpf_pkg::FIELD_BITS-1:0]    acc_y_out,
	output logic signed [iwpf_pkg::FIELD_BITS-1:0]    acc_z_out,
	output logic signed [iwpf_pkg::FIELD_BITS-1:0]    rate_x_out,
	output logic signed [iwpf_pkg::FIELD_BITS-1:0]    rate_y_out,
	output logic signed [iwpf_pkg::FIELD_BITS-1:0]    rate_z_out,
	output logic [iwpf_pkg::AXES-1:0]                 rejected_mask
);

	logic [iwpf_pkg::CFG_BITS-1:0]  gravity_q;
	logic [iwpf_pkg::CFG_BITS-1:0]  acc_tol_q;
	logic [iwpf_pkg::CFG_BITS-1:0]  gyro_floor_q;
	logic [iwpf_pkg::DROP_BITS-1:0] max_acc_q;
	logic [iwpf_pkg::DROP_BITS-1:0] max_gyro_q;

	logic v_s1, v_s2, out_valid_q, have_prev_q;
	logic rdy_out, en_s1, en_s2, take;
	logic [iwpf_pkg::AXES-1:0] rej;
	logic [iwpf_pkg::AXES-1:0] mask_q;
	iwpf_pkg::lane_ctl_t ctl;

	logic signed [iwpf_pkg::FIELD_BITS-1:0] raw  [iwpf_pkg::AXES];
	logic signed [SAMPLE_BITS-1:0]          cur  [iwpf_pkg::AXES];
	logic signed [iwpf_pkg::FIELD_BITS-1:0] held [iwpf_pkg::AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q    <= iwpf_pkg::GRAVITY_SCALE_RST;
			acc_tol_q    <= iwpf_pkg::ACC_TOLERANCE_RST;
			gyro_floor_q <= iwpf_pkg::GYRO_NOISE_FLOOR_RST;
			max_acc_q    <= iwpf_pkg::MAX_ACC_DROPS_RST;
			max_gyro_q   <= iwpf_pkg::MAX_GYRO_DROPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iwpf_pkg::REG_GRAVITY_SCALE:    gravity_q    <= cfg_data;
				iwpf_pkg::REG_ACC_TOLERANCE:    acc_tol_q    <= cfg_data;
				iwpf_pkg::REG_GYRO_NOISE_FLOOR: gyro_floor_q <= cfg_data;
				iwpf_pkg::REG_MAX_ACC_DROPS:    max_acc_q    <= cfg_data[iwpf_pkg::DROP_BITS-1:0];
				iwpf_pkg::REG_MAX_GYRO_DROPS:   max_gyro_q   <= cfg_data[iwpf_pkg::DROP_BITS-1:0];
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	// Each stage loads when empty or when the stage after it moves on.
	assign rdy_out  = !out_valid_q || out_ready;
	assign en_s2    = !v_s2 || rdy_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign take     = v_s2 && rdy_out;

	assign ctl.take  = take;
	assign ctl.first = !have_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid_q <= v_s2;
			end
			if (take) begin
				have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mask_q <= rej;
		end
	end

	assign raw[0] = acc_x_in;
	assign raw[1] = acc_y_in;
	assign raw[2] = acc_z_in;
	assign raw[3] = rate_x_in;
	assign raw[4] = rate_y_in;
	assign raw[5] = rate_z_in;

	generate
		for (genvar i = 0; i < iwpf_pkg::AXES; i++) begin : g_axis
			localparam bit IS_ACC = (i < iwpf_pkg::ACC_AXES);

			iwpf_scale #(
				.SAMPLE_BITS (SAMPLE_BITS),
				.ACC         (IS_ACC)
			) u_scale (
				.clk    (clk),
				.en_s1  (en_s1),
				.en_s2  (en_s2),
				.raw    (raw[i]),
				.scale  (gravity_q),
				.cur_s2 (cur[i])
			);

			iwpf_lane #(
				.SAMPLE_BITS (SAMPLE_BITS),
				.COUNT_BITS  (COUNT_BITS),
				.GYRO        (!IS_ACC)
			) u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.cur       (cur[i]),
				.limit_cfg (IS_ACC ? acc_tol_q : gyro_floor_q),
				.max_drops (IS_ACC ? max_acc_q : max_gyro_q),
				.held      (held[i]),
				.rejected  (rej[i])
			);
		end
	endgenerate

	assign out_valid     = out_valid_q;
	assign acc_x_out     = held[0];
	assign acc_y_out     = held[1];
	assign acc_z_out     = held[2];
	assign rate_x_out    = held[3];
	assign rate_y_out    = held[4];
	assign rate_z_out    = held[5];
	assign rejected_mask = mask_q;

	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !have_prev_q) |=> (rejected_mask == '0))
		else $error("first sample after reset reported a rejection");

	a_mask_needs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (rejected_mask != '0)) |-> have_prev_q)
		else $error("rejection reported before any previous sample");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && rej[0]) |=> $stable(acc_x_out))
		else $error("rejected acceleration axis changed its output");

	a_rate_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && rej[3]) |=> $stable(rate_x_out))
		else $error("rejected rate axis changed its output");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

endmodule
